/* hw/rtl/tfhs_pkg.sv */
// ----------------------------------------------------------------------------
// tfhs_pkg
// shared types, constants and helpers of the two-fibre stress unit
// ----------------------------------------------------------------------------
`default_nettype none

package tfhs_pkg;

  localparam int DATA_W      = 32;
  localparam int FRAC_W      = 24;
  localparam int K_W         = 31;
  localparam int M_W         = 26;
  localparam int POLY_FB     = 30;
  localparam int POLY_ORDER  = 10;
  localparam int PRE_SH      = POLY_FB - FRAC_W;
  localparam int EXP_N_MAX   = DATA_W - 1 - FRAC_W;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [63:0] LN2_Q60   = 64'h0B17217F7D1CF79A;
  localparam logic [63:0] LOG2E_Q60 = 64'h171547652B82FE17;
  localparam logic [FRAC_W-1:0] LN2_Q   = FRAC_W'(LN2_Q60 >> (60 - FRAC_W));
  localparam logic [30:0]       LOG2E_Q = 31'(LOG2E_Q60 >> 30);

  localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] ONE_Q   = DATA_W'(1) << FRAC_W;
  localparam logic [31:0]              ONE_P   = 32'(1) << POLY_FB;

  typedef enum logic [2:0] {
    REG_K1   = 3'd0,
    REG_K2   = 3'd1,
    REG_A_XX = 3'd2,
    REG_A_XY = 3'd3,
    REG_A_YY = 3'd4,
    REG_B_XX = 3'd5,
    REG_B_XY = 3'd6,
    REG_B_YY = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic        [K_W-1:0] k1;
    logic        [K_W-1:0] k2;
    logic signed [M_W-1:0] a_xx;
    logic signed [M_W-1:0] a_xy;
    logic signed [M_W-1:0] a_yy;
    logic signed [M_W-1:0] b_xx;
    logic signed [M_W-1:0] b_xy;
    logic signed [M_W-1:0] b_yy;
  } fiber_cfg_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] inv_a;
    logic signed [DATA_W-1:0] inv_b;
    logic                     flag;
  } fb_item_t;

  typedef struct packed {
    logic s1_valid;
    logic s2_valid;
  } front_status_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] v;
    logic                     f;
  } sat_t;

  // clip a wide signed value to the data range
  function automatic sat_t sat_s(input logic signed [71:0] x);
    sat_t res;
    if (x > 72'(SAT_MAX)) begin
      res.v = SAT_MAX;
      res.f = 1'b1;
    end else if (x < 72'(SAT_MIN)) begin
      res.v = SAT_MIN;
      res.f = 1'b1;
    end else begin
      res.v = x[DATA_W-1:0];
      res.f = 1'b0;
    end
    return res;
  endfunction

  // floor(2^32 / k) for the horner divisors
  function automatic logic [32:0] recip(input logic [3:0] k);
    logic [32:0] m;
    case (k)
      4'd1:    m = 33'd4294967296;
      4'd2:    m = 33'd2147483648;
      4'd3:    m = 33'd1431655765;
      4'd4:    m = 33'd1073741824;
      4'd5:    m = 33'd858993459;
      4'd6:    m = 33'd715827882;
      4'd7:    m = 33'd613566756;
      4'd8:    m = 33'd536870912;
      4'd9:    m = 33'd477218588;
      4'd10:   m = 33'd429496729;
      default: m = 33'd0;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/two_fiber_hyperelastic_stress_2d_unit.sv */
// ----------------------------------------------------------------------------
// two_fiber_hyperelastic_stress_2d_unit
// two-fibre hyperelastic stress of a 2d cauchy-green tensor, signed q8.24
// ----------------------------------------------------------------------------
// The unit takes one item (c_xx, c_xy, c_yx, c_yy) in every clock cycle
// while busy is low and returns one result per item, in order, marked by a
// one-cycle done strobe. An item passes the front that forms both fibre
// invariants, the item queue and the back, where the exponential takes ten
// horner steps at 3 registered stages each (multiply, reciprocal multiply,
// fix-up). There is no way to hold results off, so results must be taken
// as they appear; busy only rises if the queue could fill, which cannot
// happen since the back takes an item every cycle. Register writes take
// effect at once and are meant for idle periods only.
// ----------------------------------------------------------------------------
`default_nettype none

module two_fiber_hyperelastic_stress_2d_unit import tfhs_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic                     clk,
  input  logic                     rst,
  // item side
  input  logic                     start,
  output logic                     busy,
  input  logic signed [DATA_W-1:0] c_xx,
  input  logic signed [DATA_W-1:0] c_xy,
  input  logic signed [DATA_W-1:0] c_yx,
  input  logic signed [DATA_W-1:0] c_yy,
  // register write port
  input  logic                     wr_en,
  input  logic [2:0]               wr_index,
  input  logic [K_W-1:0]           wr_data,
  // result side
  output logic                     done,
  output logic signed [DATA_W-1:0] s_xx,
  output logic signed [DATA_W-1:0] s_xy,
  output logic signed [DATA_W-1:0] s_yy,
  output logic                     saturated
);

  localparam int CNT_W = $clog2(DEPTH+1);

  // configuration registers
  logic [K_W-1:0]        k1, k2;
  logic signed [M_W-1:0] a_xx, a_xy, a_yy, b_xx, b_xy, b_yy;
  fiber_cfg_t            cfg;

  logic                  accept;
  logic                  push;
  fb_item_t              push_item;
  front_status_t         status;
  logic                  pop;
  fb_item_t              pop_item;
  logic [CNT_W-1:0]      level;
  logic [CNT_W:0]        pending;

  // weight entries keep the low 26 bits of the written word as a signed field
  always_ff @(posedge clk) begin
    if (rst) begin
      k1   <= '0;
      k2   <= '0;
      a_xx <= M_W'(ONE_Q);
      a_xy <= '0;
      a_yy <= '0;
      b_xx <= M_W'(ONE_Q);
      b_xy <= '0;
      b_yy <= '0;
    end else if (wr_en) begin
      case (reg_idx_t'(wr_index))
        REG_K1:   k1   <= wr_data;
        REG_K2:   k2   <= wr_data;
        REG_A_XX: a_xx <= wr_data[M_W-1:0];
        REG_A_XY: a_xy <= wr_data[M_W-1:0];
        REG_A_YY: a_yy <= wr_data[M_W-1:0];
        REG_B_XX: b_xx <= wr_data[M_W-1:0];
        REG_B_XY: b_xy <= wr_data[M_W-1:0];
        REG_B_YY: b_yy <= wr_data[M_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.k1   = k1;
  assign cfg.k2   = k2;
  assign cfg.a_xx = a_xx;
  assign cfg.a_xy = a_xy;
  assign cfg.a_yy = a_yy;
  assign cfg.b_xx = b_xx;
  assign cfg.b_xy = b_xy;
  assign cfg.b_yy = b_yy;

  // credit check: queued items plus those still in the front
  assign pending = (CNT_W+1)'(level) + (CNT_W+1)'(status.s1_valid)
                 + (CNT_W+1)'(status.s2_valid);
  assign busy    = (pending >= (CNT_W+1)'(DEPTH));
  assign accept  = start && !busy;

  tfhs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .c_xx      (c_xx),
    .c_xy      (c_xy),
    .c_yx      (c_yx),
    .c_yy      (c_yy),
    .cfg       (cfg),
    .push      (push),
    .push_item (push_item),
    .status    (status)
  );

  tfhs_queue #(
    .DEPTH (DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .level     (level)
  );

  // back end: exponential pipeline and stress assembly
  tfhs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pop),
    .in_item   (pop_item),
    .cfg       (cfg),
    .done      (done),
    .s_xx      (s_xx),
    .s_xy      (s_xy),
    .s_yy      (s_yy),
    .saturated (saturated)
  );

`ifndef SYNTHESIS
  // an item never arrives at a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && !pop && (level == CNT_W'(DEPTH))))
    else $error("item pushed into full queue");

  // queue level stays within depth
  a_level_range: assert property (@(posedge clk) disable iff (rst)
    level <= CNT_W'(DEPTH))
    else $error("queue level beyond depth");

  // nothing in flight means the unit is free
  a_idle_free: assert property (@(posedge clk) disable iff (rst)
    ((level == '0) && !status.s1_valid && !status.s2_valid) |-> !busy)
    else $error("busy while empty");
`endif

endmodule

`default_nettype wire

/* hw/rtl/tfhs_front.sv */
// ----------------------------------------------------------------------------
// tfhs_front
// takes items in and forms both fibre invariants over two stages
// ----------------------------------------------------------------------------
`default_nettype none

module tfhs_front import tfhs_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     accept,
  input  logic signed [DATA_W-1:0] c_xx,
  input  logic signed [DATA_W-1:0] c_xy,
  input  logic signed [DATA_W-1:0] c_yx,
  input  logic signed [DATA_W-1:0] c_yy,
  input  fiber_cfg_t               cfg,
  output logic                     push,
  output fb_item_t                 push_item,
  output front_status_t            status
);

  logic                     s1_valid;
  logic                     s2_valid;
  logic signed [DATA_W-1:0] s1_xx;
  logic signed [DATA_W:0]   s1_xy;
  logic signed [DATA_W-1:0] s1_yy;
  logic signed [57:0]       pa_xx, pa_yy, pb_xx, pb_yy;
  logic signed [58:0]       pa_xy, pb_xy;
  logic signed [M_W-1:0]    ma_xx, ma_xy, ma_yy, mb_xx, mb_xy, mb_yy;
  logic signed [60:0]       dot_a, dot_b;
  logic signed [37:0]       pre_a, pre_b;
  sat_t                     inv_a, inv_b;

  assign ma_xx = cfg.a_xx;
  assign ma_xy = cfg.a_xy;
  assign ma_yy = cfg.a_yy;
  assign mb_xx = cfg.b_xx;
  assign mb_xy = cfg.b_xy;
  assign mb_yy = cfg.b_yy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
      s2_valid <= s1_valid;
    end
  end

  // off-diagonal terms share one weight, so add them first
  always_ff @(posedge clk) begin
    s1_xx <= c_xx;
    s1_xy <= 33'(c_xy) + 33'(c_yx);
    s1_yy <= c_yy;
    pa_xx <= ma_xx * s1_xx;
    pa_xy <= ma_xy * s1_xy;
    pa_yy <= ma_yy * s1_yy;
    pb_xx <= mb_xx * s1_xx;
    pb_xy <= mb_xy * s1_xy;
    pb_yy <= mb_yy * s1_yy;
  end

  always_comb begin
    dot_a = 61'(pa_xx) + 61'(pa_xy) + 61'(pa_yy);
    dot_b = 61'(pb_xx) + 61'(pb_xy) + 61'(pb_yy);
    pre_a = 38'(dot_a >>> FRAC_W) - 38'(ONE_Q);
    pre_b = 38'(dot_b >>> FRAC_W) - 38'(ONE_Q);
    inv_a = sat_s(72'(pre_a));
    inv_b = sat_s(72'(pre_b));
  end

  assign push            = s2_valid;
  assign push_item.inv_a = inv_a.v;
  assign push_item.inv_b = inv_b.v;
  assign push_item.flag  = inv_a.f | inv_b.f;
  assign status.s1_valid = s1_valid;
  assign status.s2_valid = s2_valid;

endmodule

`default_nettype wire

/* hw/rtl/tfhs_queue.sv */
// ----------------------------------------------------------------------------
// tfhs_queue
// short item queue between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module tfhs_queue import tfhs_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  fb_item_t                   push_item,
  output logic                       pop,
  output fb_item_t                   pop_item,
  output logic [$clog2(DEPTH+1)-1:0] level
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH+1);

  fb_item_t          slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [CNT_W-1:0]  count, count_next;

  // the back never stalls, so any waiting item leaves at once
  assign pop      = (count != '0);
  assign pop_item = slots[rd_ptr];
  assign level    = count;

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + CNT_W'(1);
    end else if (pop && !push) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH-1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH-1)) ? '0 : rd_ptr + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/tfhs_back.sv */
// ----------------------------------------------------------------------------
// tfhs_back
// strain energy derivative per fibre and stress assembly, fully pipelined
// ----------------------------------------------------------------------------
`default_nettype none

module tfhs_back import tfhs_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  fb_item_t                 in_item,
  input  fiber_cfg_t               cfg,
  output logic                     done,
  output logic signed [DATA_W-1:0] s_xx,
  output logic signed [DATA_W-1:0] s_xy,
  output logic signed [DATA_W-1:0] s_yy,
  output logic                     saturated
);

  localparam int LAT = 6 + 3*POLY_ORDER + 5;

  typedef struct packed {
    logic [POLY_FB-1:0]       rp;
    logic [2:0]               n;
    logic                     ovf;
    logic signed [DATA_W-1:0] kin;
    logic                     flg;
  } carry_t;

  logic [LAT-1:0]           vld;
  logic signed [DATA_W-1:0] dw [2];
  logic                     dw_f [2];
  logic signed [M_W-1:0]    ma_xx, ma_xy, ma_yy, mb_xx, mb_xy, mb_yy;

  assign ma_xx = cfg.a_xx;
  assign ma_xy = cfg.a_xy;
  assign ma_yy = cfg.a_yy;
  assign mb_xx = cfg.b_xx;
  assign mb_xy = cfg.b_xy;
  assign mb_yy = cfg.b_yy;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  assign done = vld[LAT-1];

  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic signed [DATA_W-1:0] inv;
    logic                     flg_in;
    logic signed [DATA_W-1:0] k1s;
    // stage 0..4
    logic signed [63:0]       sqp, kinp;
    logic                     f0;
    logic [30:0]              sq;
    logic signed [DATA_W-1:0] kin1, kin2, kin3, kin4;
    logic                     f1, f2, f3, f4;
    logic [61:0]              argp;
    logic [30:0]              arg3, arg4;
    logic [61:0]              nl;
    sat_t                     sq_s, kin_s;
    logic [37:0]              arg_w;
    // range reduction
    logic [7:0]               n_raw;
    logic [31:0]              r0, r1, r2;
    logic [8:0]               n1, n2;
    carry_t                   c5;
    // horner
    logic [61:0]              h_prod [POLY_ORDER];
    logic [64:0]              h_qm   [POLY_ORDER];
    logic [31:0]              h_q    [POLY_ORDER];
    logic [31:0]              h_p    [POLY_ORDER];
    carry_t                   hc_a   [POLY_ORDER];
    carry_t                   hc_b   [POLY_ORDER];
    carry_t                   hc_c   [POLY_ORDER];
    // tail
    logic [37:0]              vw;
    logic signed [DATA_W-1:0] e, kin_e;
    logic                     fe;
    logic signed [63:0]       dwp;
    logic                     fd;
    sat_t                     dw_s;

    assign inv    = (l == 0) ? in_item.inv_a : in_item.inv_b;
    assign flg_in = (l == 0) ? in_item.flag : 1'b0;
    assign k1s    = {1'b0, cfg.k1};

    always_comb begin
      sq_s  = sat_s(72'(sqp >>> FRAC_W));
      kin_s = sat_s(72'(kinp >>> FRAC_W));
      arg_w = 38'(argp >> FRAC_W);
    end

    always_ff @(posedge clk) begin
      sqp  <= inv * inv;
      kinp <= k1s * inv;
      f0   <= flg_in;
      sq   <= sq_s.v[30:0];
      kin1 <= kin_s.v;
      f1   <= f0 | sq_s.f | kin_s.f;
      argp <= cfg.k2 * sq;
      kin2 <= kin1;
      f2   <= f1;
      if (arg_w > 38'(SAT_MAX)) begin
        arg3 <= SAT_MAX[30:0];
        f3   <= 1'b1;
      end else begin
        arg3 <= arg_w[30:0];
        f3   <= f2;
      end
      kin3 <= kin2;
      nl   <= arg3 * LOG2E_Q;
      arg4 <= arg3;
      kin4 <= kin3;
      f4   <= f3;
    end

    // x = n*ln2 + r with 0 <= r < ln2
    always_comb begin
      n_raw = nl[61:54];
      r0    = 32'(arg4) - 32'(n_raw) * 32'(LN2_Q);
      n1    = 9'(n_raw);
      r1    = r0;
      if (r0 >= 32'(LN2_Q)) begin
        r1 = r0 - 32'(LN2_Q);
        n1 = 9'(n_raw) + 9'd1;
      end
      n2 = n1;
      r2 = r1;
      if (r1 >= 32'(LN2_Q)) begin
        r2 = r1 - 32'(LN2_Q);
        n2 = n1 + 9'd1;
      end
    end

    always_ff @(posedge clk) begin
      c5.rp  <= POLY_FB'(r2) << PRE_SH;
      c5.n   <= n2[2:0];
      c5.ovf <= (n2 >= 9'(EXP_N_MAX));
      c5.kin <= kin4;
      c5.flg <= f4;
    end

    for (genvar j = 0; j < POLY_ORDER; j++) begin : g_step
      localparam logic [3:0] KD = 4'(POLY_ORDER - j);
      logic [31:0] p_in;
      carry_t      c_in;
      logic [31:0] q;
      logic [31:0] est0, est1, est2;
      logic [35:0] rem0, rem1;
      logic        cr1, cr2;

      assign p_in = (j == 0) ? ONE_P : h_p[(j == 0) ? 0 : j-1];
      assign c_in = (j == 0) ? c5 : hc_c[(j == 0) ? 0 : j-1];
      assign q    = h_prod[j][61:30];

      // quotient by reciprocal, then at most two fix-ups
      always_comb begin
        est0 = h_qm[j][63:32];
        rem0 = 36'(h_q[j]) - 36'(est0) * 36'(KD);
        cr1  = (rem0 >= 36'(KD));
        est1 = est0 + 32'(cr1);
        rem1 = cr1 ? rem0 - 36'(KD) : rem0;
        cr2  = (rem1 >= 36'(KD));
        est2 = est1 + 32'(cr2);
      end

      always_ff @(posedge clk) begin
        h_prod[j] <= p_in * c_in.rp;
        hc_a[j]   <= c_in;
        h_qm[j]   <= q * recip(KD);
        h_q[j]    <= q;
        hc_b[j]   <= hc_a[j];
        h_p[j]    <= ONE_P + est2;
        hc_c[j]   <= hc_b[j];
      end
    end

    assign vw = (38'(h_p[POLY_ORDER-1]) << hc_c[POLY_ORDER-1].n) >> PRE_SH;

    always_ff @(posedge clk) begin
      kin_e <= hc_c[POLY_ORDER-1].kin;
      if (hc_c[POLY_ORDER-1].ovf || (vw > 38'(SAT_MAX))) begin
        e  <= SAT_MAX;
        fe <= 1'b1;
      end else begin
        e  <= vw[DATA_W-1:0];
        fe <= hc_c[POLY_ORDER-1].flg;
      end
      dwp <= kin_e * e;
      fd  <= fe;
    end

    assign dw_s = sat_s(72'(dwp >>> FRAC_W));

    always_ff @(posedge clk) begin
      dw[l]   <= dw_s.v;
      dw_f[l] <= fd | dw_s.f;
    end
  end

  // stress assembly
  logic signed [57:0] pxa, pxb, pya, pyb, pza, pzb;
  logic               fc;
  logic signed [58:0] sum_xx, sum_xy, sum_yy;
  sat_t               r_xx, r_xy, r_yy;

  always_ff @(posedge clk) begin
    pxa <= dw[0] * ma_xx;
    pxb <= dw[1] * mb_xx;
    pya <= dw[0] * ma_xy;
    pyb <= dw[1] * mb_xy;
    pza <= dw[0] * ma_yy;
    pzb <= dw[1] * mb_yy;
    fc  <= dw_f[0] | dw_f[1];
  end

  always_comb begin
    sum_xx = 59'(pxa) + 59'(pxb);
    sum_xy = 59'(pya) + 59'(pyb);
    sum_yy = 59'(pza) + 59'(pzb);
    r_xx   = sat_s(72'(sum_xx >>> FRAC_W));
    r_xy   = sat_s(72'(sum_xy >>> FRAC_W));
    r_yy   = sat_s(72'(sum_yy >>> FRAC_W));
  end

  always_ff @(posedge clk) begin
    s_xx      <= r_xx.v;
    s_xy      <= r_xy.v;
    s_yy      <= r_yy.v;
    saturated <= fc | r_xx.f | r_xy.f | r_yy.f;
  end

endmodule

`default_nettype wire
